// File: rtl/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types for the bounded deque: operation and status codes, controller
// states and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// Operation carried by an input beat
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	// Result status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;    // input beat taken: update pointers, write or read
		logic load_push; // load output register with a push result
		logic load_pop;  // load output register with a pop result
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/bdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller for the bounded deque. Takes input beats when idle and the output slot
// is free, holds pops in a read state for the registered memory read, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_is_pop,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output bdq_pkg::cmd_t      cmd
);

	bdq_pkg::state_t state_q, state_d;
	logic            out_valid_q, out_valid_d;
	logic            slot_free;

	// Output slot is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// State and valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && out_stall;
		in_stall    = 1'b1;
		cmd         = '0;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				in_stall = !slot_free;
				if (in_valid && slot_free) begin
					cmd.accept = 1'b1;
					if (in_is_pop) begin
						state_d = bdq_pkg::S_READ;
					end else begin
						cmd.load_push = 1'b1;
						out_valid_d   = 1'b1;
					end
				end
			end
			bdq_pkg::S_READ: begin
				if (slot_free) begin
					cmd.load_pop = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = bdq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bdq_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/bdq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath for the bounded deque: ring buffer memory, front and back
// pointers, entry count, pending pop result and the output register.
// ----------------------------------------------------------------------------
module bdq_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 4,
	parameter int CW         = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bdq_pkg::cmd_t        cmd,
	input  wire logic [1:0]           mode,
	input  wire logic signed [31:0]   push_value,
	output logic signed [31:0]        pop_value,
	output logic [1:0]                status,
	output logic [CW-1:0]             occupancy
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [0:DEPTH-1];
	logic [DATA_WIDTH-1:0] rd_s1;
	logic [AW-1:0]         front_q, back_q;
	logic [CW-1:0]         count_q;
	bdq_pkg::status_t      pend_status_q;
	logic [CW-1:0]         pend_occ_q;
	logic signed [31:0]    pop_value_q;
	bdq_pkg::status_t      status_q;
	logic [CW-1:0]         occ_q;

	logic                  full, empty;
	logic [AW-1:0]         front_prev, front_next, back_prev, back_next;
	logic [DATA_WIDTH+31:0] wr_wide;
	logic [DATA_WIDTH+31:0] rd_wide;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  we, re;
	logic [AW-1:0]         wr_addr, rd_addr;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);

	// Wrap pointers at the ring ends
	assign front_prev = (front_q == '0) ? LAST : front_q - AW'(1);
	assign front_next = (front_q == LAST) ? '0 : front_q + AW'(1);
	assign back_prev  = (back_q == '0) ? LAST : back_q - AW'(1);
	assign back_next  = (back_q == LAST) ? '0 : back_q + AW'(1);

	// Keep the low DATA_WIDTH bits of the pushed word
	assign wr_wide = {{DATA_WIDTH{1'b0}}, push_value};
	assign wr_data = wr_wide[DATA_WIDTH-1:0];
	// Return stored bits zero-extended into the result word
	assign rd_wide = {32'b0, rd_s1};

	// Decode memory access for the accepted beat
	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		wr_addr = back_q;
		rd_addr = front_q;
		unique case (bdq_pkg::op_t'(mode))
			bdq_pkg::OP_PUSH_FRONT: begin
				we      = cmd.accept && !full;
				wr_addr = front_prev;
			end
			bdq_pkg::OP_PUSH_BACK: begin
				we      = cmd.accept && !full;
				wr_addr = back_q;
			end
			bdq_pkg::OP_POP_FRONT: begin
				re      = cmd.accept && !empty;
				rd_addr = front_q;
			end
			bdq_pkg::OP_POP_BACK: begin
				re      = cmd.accept && !empty;
				rd_addr = back_prev;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Ring buffer memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			unique case (bdq_pkg::op_t'(mode))
				bdq_pkg::OP_PUSH_FRONT: begin
					if (!full) begin
						front_q <= front_prev;
						count_q <= count_q + CW'(1);
					end
				end
				bdq_pkg::OP_PUSH_BACK: begin
					if (!full) begin
						back_q  <= back_next;
						count_q <= count_q + CW'(1);
					end
				end
				bdq_pkg::OP_POP_FRONT: begin
					if (!empty) begin
						front_q <= front_next;
						count_q <= count_q - CW'(1);
					end
				end
				bdq_pkg::OP_POP_BACK: begin
					if (!empty) begin
						back_q  <= back_prev;
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Hold pop status until the read data arrives
	always_ff @(posedge clk) begin
		if (cmd.accept && mode[1]) begin
			pend_status_q <= empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
			pend_occ_q    <= empty ? count_q : count_q - CW'(1);
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.load_push) begin
			pop_value_q <= '0;
			status_q    <= full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
			occ_q       <= full ? count_q : count_q + CW'(1);
		end else if (cmd.load_pop) begin
			pop_value_q <= (pend_status_q == bdq_pkg::ST_OK) ? rd_wide[31:0] : '0;
			status_q    <= pend_status_q;
			occ_q       <= pend_occ_q;
		end
	end

	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule
`default_nettype wire

// File: rtl/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of DEPTH signed words in a ring buffer.
// Push results are registered straight into the output register; a pop result
// waits in a read state for the registered read of the ring memory. Throughput:
// pushes 1 per cycle while out_stall is low; no beat is taken during a pop's read.
// Reset: arst_n clears pointers, count and valid flags; memory is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module bounded_deque #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic signed [31:0] push_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pop_value,
	output logic [1:0]              status,
	output logic [CW-1:0]           occupancy
);

	bdq_pkg::cmd_t cmd;

	// Controller
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_is_pop (mode[1]),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath
	bdq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW),
		.CW         (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.push_value (push_value),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy)
	);

	// An accepted push shows its result on the next cycle
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !mode[1] |=> out_valid)
		else $error("push beat produced no result");

	// A full error reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bdq_pkg::ST_FULL) |-> occupancy == CW'(DEPTH))
		else $error("full status with queue not full");

	// An empty error reports an empty queue and a zero word
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bdq_pkg::ST_EMPTY) |-> (occupancy == '0) && (pop_value == '0))
		else $error("empty status with bad result");

	// Occupancy stays within the ring size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CW'(DEPTH))
		else $error("occupancy above depth");

endmodule
`default_nettype wire
